// ===== src/deq_pkg.sv =====
// shared constants and command/status codes for the double-ended queue
// no dependencies; used by the channel interfaces and the top level

package deq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_W_DEF = $clog2(DEPTH_DEF + 1);

  // value reported for an empty end or for a command that pops nothing
  localparam logic [DATA_W-1:0] NONE_VALUE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// ===== src/deq_if.sv =====
// valid/ready channels for the double-ended queue: command items in, result items out
// depends on deq_pkg for field widths

interface deq_in_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::CMD_W-1:0]   command;
  logic signed [deq_pkg::DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_out_if #(
  parameter int unsigned CNT_W = deq_pkg::CNT_W_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::DATA_W-1:0] removed_value;
  logic [deq_pkg::ST_W-1:0]          status;
  logic signed [deq_pkg::DATA_W-1:0] front_value;
  logic signed [deq_pkg::DATA_W-1:0] back_value;
  logic [CNT_W-1:0]                  count;

  modport source (output valid, output removed_value, output status, output front_value,
                  output back_value, output count, input ready);
  modport sink   (input valid, input removed_value, input status, input front_value,
                  input back_value, input count, output ready);
endinterface

// ===== src/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values in a circular memory of DEPTH entries.
// Each command item (push front/back, pop front/back, peek) gives one result item with the
// popped value, a status, the front and back values after the step and the count. The two end
// values are kept in registers, so pushes, peeks, refused commands and pops that empty the queue
// write their result straight into the output register; a pop that leaves elements first enters
// a read state, in which the new end value arrives from the single-port-read memory's registered
// read data. A result waits in an output register, and the next item is taken in the same cycle
// the waiting result leaves. Depends on deq_pkg and the channel interfaces in deq_if.sv.

module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  deq_in_if.sink  cmd_i,
  deq_out_if.source res_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DW    = deq_pkg::DATA_W;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] front_idx_q, front_idx_d;
  logic [IDX_W-1:0] back_idx_q, back_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [DW-1:0]    front_val_q, front_val_d;
  logic [DW-1:0]    back_val_q, back_val_d;
  logic             pend_front_q, pend_front_d;

  logic                     out_valid_q, out_valid_d;
  logic [DW-1:0]            out_popped_q, out_popped_d;
  logic [deq_pkg::ST_W-1:0] out_status_q, out_status_d;
  logic [DW-1:0]            out_front_q, out_front_d;
  logic [DW-1:0]            out_back_q, out_back_d;
  logic [CNT_W-1:0]         out_count_q, out_count_d;

  logic [DW-1:0]    entry_mem_q [DEPTH];
  logic [DW-1:0]    rdata_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;

  logic             accept;
  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic             is_full, is_empty;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    idx_inc = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    idx_dec = (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
  endfunction

  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || res_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign front_inc = idx_inc(front_idx_q);
  assign front_dec = idx_dec(front_idx_q);
  assign back_inc  = idx_inc(back_idx_q);
  assign back_dec  = idx_dec(back_idx_q);
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);

  always_comb begin
    state_d      = state_q;
    front_idx_d  = front_idx_q;
    back_idx_d   = back_idx_q;
    count_d      = count_q;
    front_val_d  = front_val_q;
    back_val_d   = back_val_q;
    pend_front_d = pend_front_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_popped_d = out_popped_q;
    out_status_d = out_status_q;
    out_front_d  = out_front_q;
    out_back_d   = out_back_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wa       = front_dec;
    mem_ra       = front_inc;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_popped_d = deq_pkg::NONE_VALUE;
          out_status_d = deq_pkg::ST_OK;
          case (cmd_i.command)
            deq_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                out_status_d = deq_pkg::ST_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_wa      = front_dec;
                front_idx_d = front_dec;
                front_val_d = cmd_i.value;
                if (is_empty) back_val_d = cmd_i.value;
                count_d     = count_q + 1'b1;
              end
            end
            deq_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                out_status_d = deq_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = back_inc;
                back_idx_d = back_inc;
                back_val_d = cmd_i.value;
                if (is_empty) front_val_d = cmd_i.value;
                count_d    = count_q + 1'b1;
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                out_status_d = deq_pkg::ST_EMPTY;
              end else begin
                out_popped_d = front_val_q;
                front_idx_d  = front_inc;
                count_d      = count_q - 1'b1;
                // new front comes from memory unless the queue just ran dry
                if (count_q != CNT_W'(1)) begin
                  mem_re       = 1'b1;
                  mem_ra       = front_inc;
                  pend_front_d = 1'b1;
                  state_d      = S_READ;
                end
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              if (is_empty) begin
                out_status_d = deq_pkg::ST_EMPTY;
              end else begin
                out_popped_d = back_val_q;
                back_idx_d   = back_dec;
                count_d      = count_q - 1'b1;
                if (count_q != CNT_W'(1)) begin
                  mem_re       = 1'b1;
                  mem_ra       = back_dec;
                  pend_front_d = 1'b0;
                  state_d      = S_READ;
                end
              end
            end
            default: begin
              // peek and unused codes leave the queue alone
            end
          endcase
          out_count_d = count_d;
          out_front_d = (count_d == '0) ? deq_pkg::NONE_VALUE : front_val_d;
          out_back_d  = (count_d == '0) ? deq_pkg::NONE_VALUE : back_val_d;
          out_valid_d = (state_d == S_IDLE);
        end
      end
      S_READ: begin
        // output register was freed when this item was taken
        if (pend_front_q) front_val_d = rdata_q;
        else              back_val_d  = rdata_q;
        out_front_d = front_val_d;
        out_back_d  = back_val_d;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      front_idx_q  <= '0;
      back_idx_q   <= IDX_W'(DEPTH - 1);
      count_q      <= '0;
      front_val_q  <= '0;
      back_val_q   <= '0;
      pend_front_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_popped_q <= '0;
      out_status_q <= '0;
      out_front_q  <= '0;
      out_back_q   <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      front_idx_q  <= front_idx_d;
      back_idx_q   <= back_idx_d;
      count_q      <= count_d;
      front_val_q  <= front_val_d;
      back_val_q   <= back_val_d;
      pend_front_q <= pend_front_d;
      out_valid_q  <= out_valid_d;
      out_popped_q <= out_popped_d;
      out_status_q <= out_status_d;
      out_front_q  <= out_front_d;
      out_back_q   <= out_back_d;
      out_count_q  <= out_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem_q[mem_wa] <= cmd_i.value;
    if (mem_re) rdata_q <= entry_mem_q[mem_ra];
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.removed_value = out_popped_q;
  assign res_o.status        = out_status_q;
  assign res_o.front_value   = out_front_q;
  assign res_o.back_value    = out_back_q;
  assign res_o.count         = out_count_q;

  // expected back index from front and count, for checking only
  logic [IDX_W:0] back_sum;
  logic [IDX_W:0] back_chk;
  assign back_sum = {1'b0, front_idx_q} + (IDX_W+1)'(count_q) - 1'b1;
  assign back_chk = (back_sum >= (IDX_W+1)'(DEPTH)) ? back_sum - (IDX_W+1)'(DEPTH) : back_sum;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("memory read and write in the same cycle");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_IDLE && out_valid_q)
    else $error("end fetch did not complete in one cycle");

  a_back_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> back_chk[IDX_W-1:0] == back_idx_q)
    else $error("back index out of step with front index and count");

endmodule
